// ===== rtl/core/lpsd_pkg.sv =====
// Package for the length-prefixed stream deframer.
// Holds the item types, header geometry constants and status codes.
// No dependencies; every other file of the block imports it.
package lpsd_pkg;

    // Header layout: message number, then body length, both little-endian.
    localparam int unsigned HdrBytes     = 12;
    localparam int unsigned NumBytes     = 8;
    localparam int unsigned LenBytes     = 4;
    localparam int unsigned NumW         = 8 * NumBytes;
    localparam int unsigned LenW         = 8 * LenBytes;
    // The last header byte is taken straight from the input, so it is not stored.
    localparam int unsigned HdrStoreDepth = HdrBytes - 1;
    localparam int unsigned HdrCntW      = $clog2(HdrBytes);
    localparam int unsigned HdrIdxW      = $clog2(HdrStoreDepth);

    // Status codes carried in a result item.
    localparam logic StatusOk       = 1'b0;
    localparam logic StatusBadNumber = 1'b1;

    // One received stream byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } t_in_item;

    // One delivered result.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       message_end;
        logic       status;
    } t_out_item;

    // Result of one processing step, handed from the parser to the output register.
    typedef struct packed {
        logic      has_result;
        t_out_item item;
    } t_step_result;

endpackage

// ===== rtl/core/lpsd_in_reg.sv =====
// Input register of the deframer: holds one accepted item for the parser.
// Depends on lpsd_pkg for the input item type.
module lpsd_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lpsd_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    input  logic              i_advance,
    output logic              o_valid,
    output lpsd_pkg::t_in_item o_item
);
    import lpsd_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_accept;

    // A new item enters when the register is empty or its item moves on this cycle.
    assign o_in_stall = r_valid && !i_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/core/lpsd_parser.sv =====
// Framing state and per-byte decision logic of the deframer.
// Depends on lpsd_pkg for header constants, item types and status codes.
module lpsd_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr,
    input  logic                  i_cfg_raw_mode,
    input  logic                  i_advance,
    input  lpsd_pkg::t_in_item     i_item,
    output lpsd_pkg::t_step_result o_step
);
    import lpsd_pkg::*;

    logic               r_raw_mode;
    logic [HdrCntW-1:0] r_hdr_count, n_hdr_count;
    logic [NumW-1:0]    r_expected, n_expected;
    logic [LenW-1:0]    r_remaining, n_remaining;
    logic               r_in_body, n_in_body;
    logic               r_error_halt, n_error_halt;
    logic [7:0]         r_hdr_store [0:HdrStoreDepth-1];

    logic [NumW-1:0]    w_number;
    logic [LenW-1:0]    w_length;
    logic               w_hdr_last;
    logic               w_store_wr;

    // Assemble the header fields from the stored bytes and the current one.
    always_comb begin
        for (int i = 0; i < NumBytes; i++) begin
            w_number[8*i +: 8] = r_hdr_store[i];
        end
        for (int i = 0; i < LenBytes - 1; i++) begin
            w_length[8*i +: 8] = r_hdr_store[NumBytes + i];
        end
        w_length[LenW-1 -: 8] = i_item.data_byte;
    end

    assign w_hdr_last = (r_hdr_count == HdrCntW'(HdrBytes - 1));

    // Decide the result of the byte in the input register and the next state.
    always_comb begin
        n_hdr_count  = r_hdr_count;
        n_expected   = r_expected;
        n_remaining  = r_remaining;
        n_in_body    = r_in_body;
        n_error_halt = r_error_halt;
        w_store_wr   = 1'b0;
        o_step       = '0;
        o_step.item.status = StatusOk;

        if (r_raw_mode) begin
            o_step.has_result       = 1'b1;
            o_step.item.out_byte    = i_item.data_byte;
            o_step.item.byte_valid  = 1'b1;
            o_step.item.message_end = i_item.chunk_end;
        end else if (!r_error_halt) begin
            if (r_in_body) begin
                n_remaining             = r_remaining - LenW'(1);
                o_step.has_result       = 1'b1;
                o_step.item.out_byte    = i_item.data_byte;
                o_step.item.byte_valid  = 1'b1;
                if (r_remaining == LenW'(1)) begin
                    n_in_body               = 1'b0;
                    n_expected              = r_expected + NumW'(1);
                    o_step.item.message_end = 1'b1;
                end
            end else if (w_hdr_last) begin
                n_hdr_count = '0;
                if (w_number != r_expected) begin
                    n_error_halt       = 1'b1;
                    o_step.has_result  = 1'b1;
                    o_step.item.status = StatusBadNumber;
                end else if (w_length == '0) begin
                    n_expected              = r_expected + NumW'(1);
                    o_step.has_result       = 1'b1;
                    o_step.item.message_end = 1'b1;
                end else begin
                    n_remaining = w_length;
                    n_in_body   = 1'b1;
                end
            end else begin
                w_store_wr  = 1'b1;
                n_hdr_count = r_hdr_count + HdrCntW'(1);
            end
        end
    end

    // Mode register; the user must write it only while the block is idle, the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_mode <= 1'b0;
        end else if (i_cfg_wr) begin
            r_raw_mode <= i_cfg_raw_mode;
        end
    end

    // Framing state advances once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_count  <= '0;
            r_expected   <= '0;
            r_remaining  <= '0;
            r_in_body    <= 1'b0;
            r_error_halt <= 1'b0;
        end else if (i_advance) begin
            r_hdr_count  <= n_hdr_count;
            r_expected   <= n_expected;
            r_remaining  <= n_remaining;
            r_in_body    <= n_in_body;
            r_error_halt <= n_error_halt;
        end
    end

    // Header bytes are collected in order; the store has no reset.
    always_ff @(posedge i_clk) begin
        if (i_advance && w_store_wr) begin
            r_hdr_store[r_hdr_count[HdrIdxW-1:0]] <= i_item.data_byte;
        end
    end

    // The header count never reaches the header length.
    a_hdr_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_count < HdrCntW'(HdrBytes))
        else $error("header count out of range");

    // While a body is open there is at least one body byte still to come.
    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_body |-> (r_remaining != '0))
        else $error("body open with nothing remaining");

    // Once halted on a bad number, the halt holds until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error_halt |=> r_error_halt)
        else $error("error halt cleared without reset");

    // A halted framed parser produces nothing.
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error_halt && !r_raw_mode) |-> !o_step.has_result)
        else $error("result produced while halted");

endmodule

// ===== rtl/core/lpsd_out_reg.sv =====
// Output register of the deframer: holds one result item until the receiver takes it.
// Depends on lpsd_pkg for the result types.
module lpsd_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  lpsd_pkg::t_step_result i_step,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output lpsd_pkg::t_out_item    o_out_item
);
    import lpsd_pkg::*;

    logic      r_valid;
    t_out_item r_item;
    logic      w_load;

    assign w_load = i_advance && i_step.has_result;

    // Load a new result, or empty once the current one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_step.item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

// ===== rtl/core/length_prefixed_stream_deframer.sv =====
// Top level of the length-prefixed stream deframer.
// Depends on lpsd_pkg, lpsd_in_reg, lpsd_parser and lpsd_out_reg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one stream byte
//   per item. Output channel (o_out_valid / i_out_stall / o_out_item) delivers
//   at most one result item per input item. An item moves on a channel at a
//   rising edge with valid high and stall low.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
//   raw mode bit; it is always ready and must be written only while idle.
// Timing:
//   One item per cycle sustained while the output is not stalled. A result is
//   offered on the output once its item has passed the input register and the
//   decision step has loaded the output register.
// Reset:
//   Synchronous, active low. Clears the framing state, the expected number and
//   the mode bit; the parser starts on a header in framed mode.
// Stall:
//   A stalled result holds in the output register. The item in the input
//   register waits behind it, whether or not it gives a result, so o_in_stall
//   rises once the input register is full.
module length_prefixed_stream_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lpsd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lpsd_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import lpsd_pkg::*;

    logic         w_in_valid;
    t_in_item     w_in_item;
    t_step_result w_step;
    logic         w_advance;

    // The held item is processed when the output register is free or draining.
    assign w_advance   = w_in_valid && (!o_out_valid || !i_out_stall);
    assign o_cfg_ready = 1'b1;

    lpsd_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_advance  (w_advance),
        .o_valid    (w_in_valid),
        .o_item     (w_in_item)
    );

    lpsd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr       (i_cfg_valid && o_cfg_ready),
        .i_cfg_raw_mode (i_cfg_data),
        .i_advance      (w_advance),
        .i_item         (w_in_item),
        .o_step         (w_step)
    );

    lpsd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_step      (w_step),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // The input side only stalls behind a stalled, full output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // A processed item that gives a result always shows on the output next cycle.
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_step.has_result) |=> o_out_valid)
        else $error("result lost between parser and output register");

    // A status error result never carries payload or a message end.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == StatusBadNumber))
            |-> (!o_out_item.byte_valid && !o_out_item.message_end))
        else $error("malformed error result");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the length-prefixed stream deframer.
// Needs lpsd_pkg and length_prefixed_stream_deframer; drives a directed table,
// then random framed and raw phases, and checks every result against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import lpsd_pkg::*;

    // Clock, reset and block ports.
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_data  = 1'b0;

    length_prefixed_stream_deframer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Directed table rows: either a stream byte or a mode change.
    typedef enum logic [0:0] {RowByte, RowMode} t_row_kind;
    typedef struct {
        t_row_kind  kind;
        logic [7:0] data;
        logic       chunk;
        bit         typed;
        t_out_item  want;
    } t_row;

    t_row       plan[$];
    t_out_item  deframed_q[$];
    logic [7:0] frame_bytes[$];
    int         mismatch_cnt = 0;
    int         fed_cnt = 0;
    bit         tx_burst = 1'b0;
    bit         rx_burst = 1'b0;
    int         rx_hold = 0;
    logic [63:0] gen_num = '0;

    // Predictor state, mirroring the block after reset.
    logic [7:0]      hdr_seen [HdrBytes];
    int              hdr_cnt   = 0;
    logic [NumW-1:0] next_num  = '0;
    logic [LenW-1:0] body_left = '0;
    bit              in_body   = 1'b0;
    bit              halted    = 1'b0;
    logic            raw_mode  = 1'b0;

    task automatic note_fail(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("ERROR: %s", msg);
    endtask

    // Works out the result, if any, that one accepted stream byte causes.
    function automatic bit deframe_byte(input t_in_item it, output t_out_item res);
        logic [NumW-1:0] num;
        logic [LenW-1:0] len;
        res = '0;
        if (raw_mode) begin
            res.out_byte    = it.data_byte;
            res.byte_valid  = 1'b1;
            res.message_end = it.chunk_end;
            res.status      = StatusOk;
            return 1'b1;
        end
        if (halted)
            return 1'b0;
        // Body bytes pass through; the last one closes the message.
        if (in_body) begin
            body_left      = body_left - 1'b1;
            res.out_byte   = it.data_byte;
            res.byte_valid = 1'b1;
            res.status     = StatusOk;
            if (body_left == '0) begin
                in_body         = 1'b0;
                next_num        = next_num + 1'b1;
                res.message_end = 1'b1;
            end
            return 1'b1;
        end
        // Collect header bytes until the header is whole.
        hdr_seen[hdr_cnt] = it.data_byte;
        hdr_cnt++;
        if (hdr_cnt < HdrBytes)
            return 1'b0;
        hdr_cnt = 0;
        for (int i = 0; i < NumBytes; i++)
            num[8*i +: 8] = hdr_seen[i];
        for (int i = 0; i < LenBytes; i++)
            len[8*i +: 8] = hdr_seen[NumBytes + i];
        if (num != next_num) begin
            halted     = 1'b1;
            res.status = StatusBadNumber;
            return 1'b1;
        end
        if (len == '0) begin
            next_num        = next_num + 1'b1;
            res.message_end = 1'b1;
            res.status      = StatusOk;
            return 1'b1;
        end
        body_left = len;
        in_body   = 1'b1;
        return 1'b0;
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [7:0] data,
                                    input logic chunk, input bit typed,
                                    input t_out_item want);
        t_row r;
        r.kind  = kind;
        r.data  = data;
        r.chunk = chunk;
        r.typed = typed;
        r.want  = want;
        plan.insert(plan.size(), r);
    endfunction

    // Header rows; a typed result, if given, belongs to the last header byte.
    function automatic void add_header_rows(input logic [63:0] num, input logic [31:0] len,
                                            input bit typed, input t_out_item want);
        logic [8*HdrBytes-1:0] hdr;
        hdr = {len, num};
        for (int i = 0; i < HdrBytes; i++)
            add_row(RowByte, hdr[8*i +: 8], 1'b0, typed && (i == HdrBytes - 1), want);
    endfunction

    // Appends one whole message with random body bytes to the framed stream.
    task automatic queue_message(input logic [63:0] num, input logic [31:0] len);
        logic [8*HdrBytes-1:0] hdr;
        hdr = {len, num};
        for (int i = 0; i < HdrBytes; i++)
            frame_bytes.insert(frame_bytes.size(), hdr[8*i +: 8]);
        for (int i = 0; i < len; i++)
            frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
    endtask

    // Removes and returns the oldest byte of the framed stream.
    function automatic logic [7:0] take_frame_byte();
        logic [7:0] b;
        b = frame_bytes[0];
        frame_bytes.delete(0);
        return b;
    endfunction

    // Offers one item after a random gap and records what it should cause.
    task automatic feed_byte(input logic [7:0] data, input logic chunk,
                             input bit typed, input t_out_item want);
        int        gap;
        t_in_item  it;
        t_out_item res;
        bit        has;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.data_byte = data;
        it.chunk_end = chunk;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        fed_cnt++;
        has = deframe_byte(it, res);
        if (typed)
            deframed_q.insert(deframed_q.size(), want);
        else if (has)
            deframed_q.insert(deframed_q.size(), res);
    endtask

    // Stops feeding and waits until the block has nothing left in flight.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the mode register while the block is idle.
    task automatic set_mode(input logic raw);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        raw_mode = raw;
    endtask

    // Result side: random stalls per item, checked against the oldest prediction.
    always @(posedge i_clk) begin : rx_side
        t_out_item want;
        int        draw;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_hold = 0;
        end else if (o_out_valid && !i_out_stall) begin
            if (deframed_q.size() == 0) begin
                note_fail($sformatf("unexpected result: byte %02h valid %b end %b status %b",
                                    o_out_item.out_byte, o_out_item.byte_valid,
                                    o_out_item.message_end, o_out_item.status));
            end else begin
                want = deframed_q[0];
                deframed_q.delete(0);
                if (o_out_item.out_byte !== want.out_byte ||
                    o_out_item.byte_valid !== want.byte_valid ||
                    o_out_item.message_end !== want.message_end ||
                    o_out_item.status !== want.status)
                    note_fail($sformatf({"result mismatch: expected byte %02h valid %b end %b ",
                                         "status %b, got byte %02h valid %b end %b status %b"},
                                        want.out_byte, want.byte_valid, want.message_end,
                                        want.status, o_out_item.out_byte,
                                        o_out_item.byte_valid, o_out_item.message_end,
                                        o_out_item.status));
            end
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            draw = rx_burst ? 0 : $urandom_range(0, 10);
            rx_hold = draw;
            i_out_stall <= (draw > 0);
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            if (rx_hold == 0)
                i_out_stall <= 1'b0;
        end
    end

    // Main stimulus: reset, directed table, random phases, error tail, end check.
    initial begin : stim
        bit          raw;
        int          n;
        int          pick;
        logic [31:0] len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty message at number zero, raw extremes, then a one-byte message
        // whose last byte also carries a chunk end that framed mode ignores.
        add_header_rows(64'd0, 32'd0, 1'b1, t_out_item'{8'h00, 1'b0, 1'b1, StatusOk});
        add_row(RowMode, 8'd1, 1'b0, 1'b0, '0);
        add_row(RowByte, 8'hFF, 1'b1, 1'b1, t_out_item'{8'hFF, 1'b1, 1'b1, StatusOk});
        add_row(RowByte, 8'h00, 1'b0, 1'b1, t_out_item'{8'h00, 1'b1, 1'b0, StatusOk});
        add_row(RowMode, 8'd0, 1'b0, 1'b0, '0);
        add_header_rows(64'd1, 32'd1, 1'b0, '0);
        add_row(RowByte, 8'hFF, 1'b1, 1'b1, t_out_item'{8'hFF, 1'b1, 1'b1, StatusOk});

        foreach (plan[i]) begin
            if (plan[i].kind == RowMode)
                set_mode(plan[i].data[0]);
            else
                feed_byte(plan[i].data, plan[i].chunk, plan[i].typed, plan[i].want);
        end

        // Random phases; framed phases stop anywhere inside a message and
        // resume it in the next framed phase.
        gen_num = 64'd2;
        while (fed_cnt < 650) begin
            raw = ($urandom_range(0, 3) == 0);
            set_mode(raw);
            tx_burst = ($urandom_range(0, 3) == 0);
            n = $urandom_range(5, 60);
            repeat (n) begin
                if (raw) begin
                    feed_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'b0, '0);
                end else begin
                    if (frame_bytes.size() == 0) begin
                        pick = $urandom_range(0, 19);
                        if (pick < 3)
                            len = 32'd0;
                        else if (pick == 3)
                            len = $urandom_range(40, 90);
                        else
                            len = $urandom_range(1, 16);
                        queue_message(gen_num, len);
                        gen_num = gen_num + 1'b1;
                    end
                    feed_byte(take_frame_byte(), 1'($urandom_range(0, 1)), 1'b0, '0);
                end
            end
        end

        // Finish the open message, then send a header with a wrong number.
        // Later framed bytes are dropped, while raw mode still passes bytes.
        set_mode(1'b0);
        tx_burst = 1'b0;
        while (frame_bytes.size() != 0)
            feed_byte(take_frame_byte(), 1'($urandom_range(0, 1)), 1'b0, '0);
        queue_message(gen_num ^ (64'd1 << $urandom_range(0, 63)), $urandom_range(0, 6));
        while (frame_bytes.size() != 0)
            feed_byte(take_frame_byte(), 1'($urandom_range(0, 1)), 1'b0, '0);
        repeat (6)
            feed_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
        set_mode(1'b1);
        repeat (8)
            feed_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
        i_in_valid <= 1'b0;

        // Drain with a bound, then allow for the pipeline latency.
        for (n = 0; n < 5000 && deframed_q.size() != 0; n++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (deframed_q.size() != 0)
            note_fail($sformatf("%0d results never arrived", deframed_q.size()));
        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #1000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
